FILE: design/lif_conductance_neuron_update_assert.svh
// Assertion macros for the port-level neuron update checker.
`ifndef LIF_CONDUCTANCE_NEURON_UPDATE_ASSERT_SVH
`define LIF_CONDUCTANCE_NEURON_UPDATE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LCNU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LCNU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/lcnu_pkg.sv
// Shared types, constants and the NMDA block table for the neuron update block.
package lcnu_pkg;

  // Operation and synapse codes
  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] SYN_AMPA = 2'd0;
  localparam logic [1:0] SYN_NMDA = 2'd1;
  localparam logic [1:0] SYN_INH  = 2'd2;
  localparam logic [1:0] SYN_GAP  = 2'd3;

  // Configuration register indexes
  localparam int CFG_IW = 4;
  localparam logic [CFG_IW-1:0] REG_EXC_REV   = 4'd0;
  localparam logic [CFG_IW-1:0] REG_INH_REV   = 4'd1;
  localparam logic [CFG_IW-1:0] REG_REST_V    = 4'd2;
  localparam logic [CFG_IW-1:0] REG_THRESH    = 4'd3;
  localparam logic [CFG_IW-1:0] REG_STEP_GAIN = 4'd4;
  localparam logic [CFG_IW-1:0] REG_REST_G    = 4'd5;
  localparam logic [CFG_IW-1:0] REG_GAP_GAIN  = 4'd6;
  localparam logic [CFG_IW-1:0] REG_REFRACT   = 4'd7;

  // Conductance limit and decay factors (Q16)
  localparam logic [23:0] G_MAX      = 24'hFFFFFF;
  localparam logic [15:0] AMPA_DECAY = 16'd62259;
  localparam logic [15:0] NMDA_DECAY = 16'd64880;
  localparam logic [15:0] INH_DECAY  = 16'd62259;
  localparam logic [15:0] GJ_DECAY   = 16'd62259;
  localparam logic [15:0] SINCE_MAX  = 16'hFFFF;

  // Q30 constants of the Mg block curve
  localparam logic [63:0] STEP_Q30    = 64'd1007690898;
  localparam logic [63:0] BLOCK_C_Q30 = 64'd360921622;

  typedef struct packed {
    logic        op;
    logic [9:0]  neuron;
    logic [1:0]  syn;
    logic [23:0] weight;
  } cmd_t;

  typedef struct packed {
    logic signed [23:0] exc_rev;
    logic signed [23:0] inh_rev;
    logic signed [23:0] rest_v;
    logic signed [23:0] thresh;
    logic [31:0]        step_gain;
    logic [23:0]        rest_g;
    logic signed [31:0] gap_gain;
    logic [15:0]        refract;
  } cfg_t;

  // One neuron record as kept in the state memory
  typedef struct packed {
    logic [23:0] v;
    logic [23:0] ga;
    logic [23:0] gn;
    logic [23:0] gi;
    logic [23:0] gg;
    logic [15:0] since;
  } rec_t;

  // Back-end status seen by the front end
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_stat_t;

  typedef logic [15:0] blk_tab_t [256];

  // Restoring shift-subtract division, used only while building the table
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Mg voltage-block factor, Q16, indexed by potential in 1024 uV bins
  function automatic blk_tab_t build_blk_tab();
    blk_tab_t    t;
    logic [63:0] f;
    logic [63:0] den;
    t = '{default: '0};
    f = 64'd1 << 30;
    for (int k = 0; k <= 128; k++) begin
      if (128 + k < 256) begin
        den = (64'd1 << 30) + ((BLOCK_C_Q30 * f) >> 30);
        t[128 + k] = 16'(udiv64(64'd1 << 46, den));
      end
      if (k >= 1) begin
        den = f + BLOCK_C_Q30;
        t[128 - k] = 16'(udiv64(f << 16, den));
      end
      f = (f * STEP_Q30) >> 30;
    end
    return t;
  endfunction

  localparam blk_tab_t BLK_TAB = build_blk_tab();

endpackage

FILE: design/lcnu_front.sv
// Front end: accepts input words, drops out-of-range neurons, queues commands.
module lcnu_front #(
  parameter int NEURONS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,
  input  logic [2:0]        in_tuser,
  input  lcnu_pkg::bk_stat_t bk,
  output logic              q_valid,
  output lcnu_pkg::cmd_t    q_cmd
);

  lcnu_pkg::cmd_t q_mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           accept, in_range, push, pop;
  lcnu_pkg::cmd_t in_cmd;

  // Unpack and classify
  always_comb begin
    in_cmd.op     = in_tuser[0];
    in_cmd.syn    = in_tuser[2:1];
    in_cmd.neuron = in_tdata[9:0];
    in_cmd.weight = in_tdata[33:10];
  end

  assign in_range  = {22'd0, in_cmd.neuron} < 32'(NEURONS);
  assign in_tready = !bk.clearing && (cnt_r != 2'd2);
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && in_range;
  assign pop       = bk.pop;

  // Two-entry command queue
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= in_cmd;
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = q_mem_r[rd_ptr_r];

endmodule

FILE: design/lcnu_back.sv
// Back end: neuron state memory, event and tick sequencer, result register.
module lcnu_back #(
  parameter int NEURONS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lcnu_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  lcnu_pkg::cmd_t     q_cmd,
  output lcnu_pkg::bk_stat_t bk,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_neuron,
  output logic               out_fired,
  output logic [23:0]        out_v
);

  localparam int AW   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam int RECW = $bits(lcnu_pkg::rec_t);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_A    = 4'd1;
  localparam logic [3:0] ST_B    = 4'd2;
  localparam logic [3:0] ST_C    = 4'd3;
  localparam logic [3:0] ST_D    = 4'd4;
  localparam logic [3:0] ST_E    = 4'd5;
  localparam logic [3:0] ST_F    = 4'd6;
  localparam logic [3:0] ST_G    = 4'd7;

  logic [RECW-1:0] mem [NEURONS];
  logic [RECW-1:0] rd_data_r;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [RECW-1:0] mem_wdata;

  logic [3:0]      state_r, state_nxt;
  logic            clr_r;
  logic [AW-1:0]   clr_cnt_r;
  lcnu_pkg::cmd_t  cmd_r;
  lcnu_pkg::rec_t  rec;

  // Tick pipeline registers
  logic [15:0]        since_r;
  logic               integ_r;
  logic [15:0]        blk_r;
  logic signed [24:0] de_e_r, de_i_r, de_r_r;
  logic signed [56:0] gapp_r;
  logic [23:0]        ga_d_r, gn_d_r, gi_d_r, gg_d_r;
  logic [23:0]        gn_r;
  logic signed [49:0] pa_r, pi_r, pr_r, pn_r;
  logic signed [51:0] s3_r, s_r;
  logic [57:0]        plo_r;
  logic signed [58:0] phi_r;
  logic signed [52:0] dv_r;

  logic               out_valid_r;
  logic [9:0]         out_neuron_r;
  logic               out_fired_r;
  logic [23:0]        out_v_r;

  // Combinational helpers
  logic [15:0]        since_n;
  logic [17:0]        vc;
  logic [7:0]         blk_idx;
  logic [24:0]        ev_sum;
  logic [23:0]        ev_g, ev_new;
  lcnu_pkg::rec_t     ev_rec, tk_rec;
  logic [84:0]        p_full;
  logic signed [53:0] vs;
  logic [23:0]        v_sat, v_fin;
  logic signed [40:0] gapv;
  logic signed [41:0] fire_sum;
  logic               fire;
  logic               commit, out_free;

  assign rec      = lcnu_pkg::rec_t'(rd_data_r);
  assign out_free = !out_valid_r || out_ready;
  assign mem_re   = (state_r == ST_IDLE) && !clr_r && q_valid;
  assign commit   = (state_r == ST_G) && out_free;

  // State memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[AW'(q_cmd.neuron)];
  end

  // Event: saturating add to the selected conductance
  always_comb begin
    case (cmd_r.syn)
      lcnu_pkg::SYN_AMPA: ev_g = rec.ga;
      lcnu_pkg::SYN_NMDA: ev_g = rec.gn;
      lcnu_pkg::SYN_INH:  ev_g = rec.gi;
      default:            ev_g = rec.gg;
    endcase
    ev_sum = {1'b0, ev_g} + {1'b0, cmd_r.weight};
    ev_new = ev_sum[24] ? lcnu_pkg::G_MAX : ev_sum[23:0];
    ev_rec = rec;
    case (cmd_r.syn)
      lcnu_pkg::SYN_AMPA: ev_rec.ga = ev_new;
      lcnu_pkg::SYN_NMDA: ev_rec.gn = ev_new;
      lcnu_pkg::SYN_INH:  ev_rec.gi = ev_new;
      default:            ev_rec.gg = ev_new;
    endcase
  end

  // Tick, first stage: counter, block table index
  always_comb begin
    since_n = (rec.since == lcnu_pkg::SINCE_MAX) ? rec.since : rec.since + 16'd1;
    if ($signed(rec.v) < $signed(24'shFE0000))
      vc = 18'h20000;
    else if ($signed(rec.v) > $signed(24'sh01FFFF))
      vc = 18'h1FFFF;
    else
      vc = rec.v[17:0];
    blk_idx = {~vc[17], vc[16:10]};
  end

  // Tick, last stage: scale, saturate, fire test
  always_comb begin
    p_full   = {phi_r, 26'd0} + {27'd0, plo_r};
    vs       = $signed({{30{rec.v[23]}}, rec.v}) + $signed({dv_r[52], dv_r});
    if (vs > 54'sd8388607)
      v_sat = 24'h7FFFFF;
    else if (vs < -54'sd8388608)
      v_sat = 24'h800000;
    else
      v_sat = vs[23:0];
    gapv     = gapp_r[56:16];
    fire_sum = $signed({{18{v_sat[23]}}, v_sat}) + $signed({gapv[40], gapv});
    fire     = integ_r && (fire_sum > $signed({{18{cfg.thresh[23]}}, cfg.thresh}));
    v_fin    = fire ? cfg.rest_v : (integ_r ? v_sat : rec.v);
    tk_rec.v     = v_fin;
    tk_rec.ga    = ga_d_r;
    tk_rec.gn    = gn_d_r;
    tk_rec.gi    = gi_d_r;
    tk_rec.gg    = gg_d_r;
    tk_rec.since = fire ? 16'd0 : since_r;
  end

  // Memory write select: clearing pass, event or tick commit
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cmd_r.neuron);
    mem_wdata = tk_rec;
    if (clr_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = {24'd0, 24'd0, 24'd0, 24'd0, 24'd0, lcnu_pkg::SINCE_MAX};
    end else if (state_r == ST_A && cmd_r.op == lcnu_pkg::OP_EVENT) begin
      mem_we    = 1'b1;
      mem_wdata = ev_rec;
    end else if (commit) begin
      mem_we    = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (mem_re) state_nxt = ST_A;
      ST_A:    state_nxt = (cmd_r.op == lcnu_pkg::OP_EVENT) ? ST_IDLE : ST_B;
      ST_B:    state_nxt = ST_C;
      ST_C:    state_nxt = ST_D;
      ST_D:    state_nxt = ST_E;
      ST_E:    state_nxt = ST_F;
      ST_F:    state_nxt = ST_G;
      ST_G:    if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(NEURONS - 1)) clr_r <= 1'b0;
      end
      if (commit)         out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (mem_re) cmd_r <= q_cmd;
    case (state_r)
      ST_A: begin
        since_r <= since_n;
        integ_r <= since_n > cfg.refract;
        blk_r   <= lcnu_pkg::BLK_TAB[blk_idx];
        de_e_r  <= $signed({cfg.exc_rev[23], cfg.exc_rev}) - $signed({rec.v[23], rec.v});
        de_i_r  <= $signed({cfg.inh_rev[23], cfg.inh_rev}) - $signed({rec.v[23], rec.v});
        de_r_r  <= $signed({cfg.rest_v[23], cfg.rest_v}) - $signed({rec.v[23], rec.v});
        gapp_r  <= $signed(cfg.gap_gain) * $signed({1'b0, rec.gg});
        ga_d_r  <= 24'((40'(rec.ga) * 40'(lcnu_pkg::AMPA_DECAY)) >> 16);
        gn_d_r  <= 24'((40'(rec.gn) * 40'(lcnu_pkg::NMDA_DECAY)) >> 16);
        gi_d_r  <= 24'((40'(rec.gi) * 40'(lcnu_pkg::INH_DECAY)) >> 16);
        gg_d_r  <= 24'((40'(rec.gg) * 40'(lcnu_pkg::GJ_DECAY)) >> 16);
      end
      ST_B: begin
        gn_r <= 24'((40'(rec.gn) * 40'(blk_r)) >> 16);
        pa_r <= $signed({1'b0, rec.ga}) * de_e_r;
        pi_r <= $signed({1'b0, rec.gi}) * de_i_r;
        pr_r <= $signed({1'b0, cfg.rest_g}) * de_r_r;
      end
      ST_C: begin
        pn_r <= $signed({1'b0, gn_r}) * de_e_r;
        s3_r <= $signed({{2{pa_r[49]}}, pa_r}) + $signed({{2{pi_r[49]}}, pi_r})
              + $signed({{2{pr_r[49]}}, pr_r});
      end
      ST_D: s_r <= s3_r + $signed({{2{pn_r[49]}}, pn_r});
      ST_E: begin
        plo_r <= 58'(s_r[25:0]) * 58'(cfg.step_gain);
        phi_r <= $signed(s_r[51:26]) * $signed({1'b0, cfg.step_gain});
      end
      ST_F: dv_r <= $signed(p_full[84:32]);
      default: ;
    endcase
    if (commit) begin
      out_neuron_r <= cmd_r.neuron;
      out_fired_r  <= fire;
      out_v_r      <= v_fin;
    end
  end

  assign bk.pop      = mem_re;
  assign bk.clearing = clr_r;
  assign out_valid   = out_valid_r;
  assign out_neuron  = out_neuron_r;
  assign out_fired   = out_fired_r;
  assign out_v       = out_v_r;

endmodule

FILE: design/lif_conductance_neuron_update.sv
// Top level of the conductance-based LIF neuron update block.
//
//  channel | direction | words
//  in_     | slave     | synaptic event or update tick for one neuron
//  out_    | master    | one result word per in-range update tick
//  cfg_    | write     | eight model registers, index 0..7
//
// An event in the back end is a memory read, then the saturating add and its
// write-back; a tick is the memory read, integration in states A to D, scaling
// in E and F, then write-back in G. The two-entry queue lets input words land
// while the back end works. After reset a clearing pass writes every record
// with in_tready low; a stalled result holds the tick sequencer at write-back.
module lif_conductance_neuron_update #(
  parameter int NEURONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // neuron[9:0], weight[33:10], zero fill
  input  logic [2:0]  in_tuser,   // operation[0], synapse_type[2:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // neuron_out[9:0], fired[10], membrane_potential[34:11]
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  lcnu_pkg::cfg_t     cfg_r;
  lcnu_pkg::bk_stat_t bk;
  lcnu_pkg::cmd_t     q_cmd;
  logic               q_valid;
  logic [9:0]         out_neuron;
  logic               out_fired;
  logic [23:0]        out_v;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lcnu_pkg::REG_EXC_REV:   cfg_r.exc_rev   <= cfg_wdata[23:0];
        lcnu_pkg::REG_INH_REV:   cfg_r.inh_rev   <= cfg_wdata[23:0];
        lcnu_pkg::REG_REST_V:    cfg_r.rest_v    <= cfg_wdata[23:0];
        lcnu_pkg::REG_THRESH:    cfg_r.thresh    <= cfg_wdata[23:0];
        lcnu_pkg::REG_STEP_GAIN: cfg_r.step_gain <= cfg_wdata;
        lcnu_pkg::REG_REST_G:    cfg_r.rest_g    <= cfg_wdata[23:0];
        lcnu_pkg::REG_GAP_GAIN:  cfg_r.gap_gain  <= cfg_wdata;
        lcnu_pkg::REG_REFRACT:   cfg_r.refract   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  lcnu_front #(.NEURONS(NEURONS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .bk        (bk),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd)
  );

  lcnu_back #(.NEURONS(NEURONS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .bk         (bk),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_neuron (out_neuron),
    .out_fired  (out_fired),
    .out_v      (out_v)
  );

  assign out_tdata = {5'd0, out_v, out_fired, out_neuron};

endmodule

FILE: design/lcnu_checker.sv
// Port-level checker for the neuron update block, bound to the top level.
`include "lif_conductance_neuron_update_assert.svh"

module lcnu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // result word holds while stalled
  `LCNU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out word dropped")
  `LCNU_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata), "out word changed")
  // clearing pass keeps the input closed right after reset
  `LCNU_ASSERT_NOW(a_clr_closed, $past(!rst_n), !in_tready, "input open during clear")
  // no result can exist right after reset
  `LCNU_ASSERT_NOW(a_no_early_out, $past(!rst_n), !out_tvalid, "result right after reset")

endmodule

bind lif_conductance_neuron_update lcnu_checker u_lcnu_checker (.*);

FILE: bench/lcnu_checker.sv
// Checker for the neuron update block: tracks the neuron records, predicts each result, compares.
module lcnu_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0]         neuron;
    logic               fired;
    logic signed [23:0] v;
  } spike_word_t;

  // Model registers
  logic signed [23:0] c_exc, c_inh, c_rest, c_thresh;
  logic [31:0]        c_step;
  logic [23:0]        c_rest_g;
  logic signed [31:0] c_gap;
  logic [15:0]        c_refract;

  // Per-neuron records
  logic signed [23:0] pot_q   [1024];
  logic [23:0]        ampa_q  [1024];
  logic [23:0]        nmda_q  [1024];
  logic [23:0]        inh_q   [1024];
  logic [23:0]        gap_q   [1024];
  logic [15:0]        since_q [1024];

  logic [15:0]  mg_block [256];
  spike_word_t  spike_q [$];

  // Mg block factor table, Q16, 1024 uV bins around 0 V
  initial begin
    logic [63:0] f;
    f = 64'd1 << 30;
    for (int k = 0; k <= 128; k++) begin
      if (128 + k < 256)
        mg_block[128 + k] = 16'((64'd1 << 46) /
                            ((64'd1 << 30) + ((lcnu_pkg::BLOCK_C_Q30 * f) >> 30)));
      if (k >= 1)
        mg_block[128 - k] = 16'((f << 16) / (f + lcnu_pkg::BLOCK_C_Q30));
      f = (f * lcnu_pkg::STEP_Q30) >> 30;
    end
  end

  function automatic logic [23:0] fade(logic [23:0] g, logic [15:0] k);
    return 24'((48'(g) * 48'(k)) >> 16);
  endfunction

  // One update tick of neuron n
  function automatic spike_word_t tick_neuron(logic [9:0] n);
    spike_word_t        r;
    logic [15:0]        cnt;
    longint             v, vc, de, s, gn, gapv;
    logic signed [95:0] prod;
    int                 bin;
    cnt = since_q[n];
    if (cnt != lcnu_pkg::SINCE_MAX) cnt++;
    v = longint'(pot_q[n]);
    r.fired = 1'b0;
    if (cnt > c_refract) begin
      vc = v < -131072 ? -131072 : (v > 131071 ? 131071 : v);
      bin = int'((vc + 131072) >>> 10);
      gn = (longint'(nmda_q[n]) * longint'(mg_block[bin])) >>> 16;
      de = longint'(c_exc) - v;
      s = longint'(ampa_q[n]) * de + gn * de
        + longint'(inh_q[n]) * (longint'(c_inh) - v)
        + longint'(c_rest_g) * (longint'(c_rest) - v);
      prod = $signed({{32{s[63]}}, s}) * $signed({64'd0, c_step});
      v = v + longint'(prod >>> 32);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      gapv = (longint'(c_gap) * longint'(gap_q[n])) >>> 16;
      if (v + gapv > longint'(c_thresh)) begin
        r.fired = 1'b1;
        v = longint'(c_rest);
        cnt = '0;
      end
    end
    since_q[n] = cnt;
    pot_q[n]   = 24'(v);
    ampa_q[n]  = fade(ampa_q[n], lcnu_pkg::AMPA_DECAY);
    nmda_q[n]  = fade(nmda_q[n], lcnu_pkg::NMDA_DECAY);
    inh_q[n]   = fade(inh_q[n], lcnu_pkg::INH_DECAY);
    gap_q[n]   = fade(gap_q[n], lcnu_pkg::GJ_DECAY);
    r.neuron = n;
    r.v = 24'(v);
    return r;
  endfunction

  always @(posedge clk) begin
    logic [9:0]  n;
    logic [24:0] sum;
    spike_word_t exp_w, got;
    if (!rst_n) begin
      {c_exc, c_inh, c_rest, c_thresh, c_step, c_rest_g, c_gap, c_refract} <= '0;
      for (int i = 0; i < 1024; i++) begin
        pot_q[i] = '0;
        ampa_q[i] = '0;
        nmda_q[i] = '0;
        inh_q[i] = '0;
        gap_q[i] = '0;
        since_q[i] = lcnu_pkg::SINCE_MAX;
      end
      spike_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      // register writes; indexes above the last register are dropped
      if (cfg_we) begin
        case (cfg_index)
          lcnu_pkg::REG_EXC_REV:   c_exc      <= cfg_wdata[23:0];
          lcnu_pkg::REG_INH_REV:   c_inh      <= cfg_wdata[23:0];
          lcnu_pkg::REG_REST_V:    c_rest     <= cfg_wdata[23:0];
          lcnu_pkg::REG_THRESH:    c_thresh   <= cfg_wdata[23:0];
          lcnu_pkg::REG_STEP_GAIN: c_step     <= cfg_wdata;
          lcnu_pkg::REG_REST_G:    c_rest_g   <= cfg_wdata[23:0];
          lcnu_pkg::REG_GAP_GAIN:  c_gap      <= cfg_wdata;
          lcnu_pkg::REG_REFRACT:   c_refract  <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // accepted input word
      if (in_tvalid && in_tready) begin
        n = in_tdata[9:0];
        if (in_tuser[0] == lcnu_pkg::OP_EVENT) begin
          case (in_tuser[2:1])
            lcnu_pkg::SYN_AMPA: sum = 25'(ampa_q[n]) + 25'(in_tdata[33:10]);
            lcnu_pkg::SYN_NMDA: sum = 25'(nmda_q[n]) + 25'(in_tdata[33:10]);
            lcnu_pkg::SYN_INH:  sum = 25'(inh_q[n])  + 25'(in_tdata[33:10]);
            default:            sum = 25'(gap_q[n])  + 25'(in_tdata[33:10]);
          endcase
          if (sum > 25'(lcnu_pkg::G_MAX)) sum = 25'(lcnu_pkg::G_MAX);
          case (in_tuser[2:1])
            lcnu_pkg::SYN_AMPA: ampa_q[n] = sum[23:0];
            lcnu_pkg::SYN_NMDA: nmda_q[n] = sum[23:0];
            lcnu_pkg::SYN_INH:  inh_q[n]  = sum[23:0];
            default:            gap_q[n]  = sum[23:0];
          endcase
        end else begin
          spike_q.push_back(tick_neuron(n));
        end
      end
      // accepted result word
      if (out_tvalid && out_tready) begin
        got.neuron = out_tdata[9:0];
        got.fired  = out_tdata[10];
        got.v      = out_tdata[34:11];
        if (spike_q.size() == 0) begin
          if (errors < 10) $display("ERROR: result word with none expected: neuron %0d",
                                    got.neuron);
          errors <= errors + 1;
        end else begin
          exp_w = spike_q.pop_front();
          if (got.neuron !== exp_w.neuron || got.fired !== exp_w.fired
              || got.v !== exp_w.v) begin
            if (errors < 10)
              $display("ERROR: neuron %0d fired %0d v %0d, expected neuron %0d fired %0d v %0d",
                       got.neuron, got.fired, got.v, exp_w.neuron, exp_w.fired, exp_w.v);
            errors <= errors + 1;
          end
        end
      end
      pending <= spike_q.size();
    end
  end
endmodule

FILE: bench/tb_top.sv
// Stimulus and verdict for the neuron update block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // neuron[9:0], weight[33:10], zero fill
  logic [2:0]  in_tuser = '0;   // operation[0], synapse_type[2:1]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // neuron_out[9:0], fired[10], membrane_potential[34:11]
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int          errors, pending;
  int          snd_idle = 36, rcv_idle = 57, words_sent = 0;
  logic [9:0]  pool [6];

  always #10 clk = ~clk;

  lif_conductance_neuron_update dut (.*);
  lcnu_tb_checker chk (.*);

  // result side stalls
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= rcv_idle);
  end

  // one input word, with a random gap ahead of it
  task automatic send_word(logic op, logic [9:0] n, logic [1:0] syn, logic [23:0] w);
    if (words_sent == 400) begin
      snd_idle = 57;
      rcv_idle = 36;
    end else if (words_sent == 800) begin
      snd_idle = 0;
      rcv_idle = 0;
    end
    if ($urandom_range(99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, w, n};
    in_tuser  <= {syn, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // drain results, then let a trailing event finish
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register set: 0 plausible, 1 all high with no refractory, 2 all low with full refractory, 3 raw words
  task automatic load_regs(int kind);
    logic [31:0] r [8];
    int          rest;
    rest = -int'($urandom_range(75000, 55000));
    r[lcnu_pkg::REG_EXC_REV]   = 32'($urandom_range(20000));
    r[lcnu_pkg::REG_INH_REV]   = 32'(-int'($urandom_range(90000, 60000)));
    r[lcnu_pkg::REG_REST_V]    = 32'(rest);
    r[lcnu_pkg::REG_THRESH]    = 32'(rest + int'($urandom_range(25000, 5000)));
    r[lcnu_pkg::REG_STEP_GAIN] = $urandom_range(32'h20000, 32'h400);
    r[lcnu_pkg::REG_REST_G]    = $urandom_range(20000);
    r[lcnu_pkg::REG_GAP_GAIN]  = 32'(int'($urandom_range(32'h40000)) - 32'h20000);
    r[lcnu_pkg::REG_REFRACT]   = $urandom_range(5);
    if (kind == 1) begin
      r = '{32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'hFFFFFFFF, 32'hFFFFFF,
            32'h7FFFFFFF, 32'h0};
    end else if (kind == 2) begin
      r = '{32'h800000, 32'h800000, 32'h800000, 32'h800000, 32'h0, 32'h0,
            32'h80000000, 32'hFFFF};
    end else if (kind == 3) begin
      foreach (r[i]) r[i] = $urandom();
    end
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 4'(i);
      cfg_wdata <= r[i];
      @(posedge clk);
    end
    // index past the register file must not land anywhere
    cfg_index <= 4'($urandom_range(15, 8));
    cfg_wdata <= $urandom();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #10ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int kinds [6];
    logic [23:0] w;
    kinds = '{1, 2, 3, 0, 0, 3};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);

    // directed: each synapse, zero and full weights, saturation, both end neurons
    load_regs(0);
    send_word(lcnu_pkg::OP_EVENT, 10'd0, lcnu_pkg::SYN_AMPA, 24'd0);
    send_word(lcnu_pkg::OP_EVENT, 10'd0, lcnu_pkg::SYN_NMDA, 24'hFFFFFF);
    send_word(lcnu_pkg::OP_EVENT, 10'd0, lcnu_pkg::SYN_INH, 24'd1);
    send_word(lcnu_pkg::OP_EVENT, 10'd0, lcnu_pkg::SYN_GAP, 24'hFFFFFF);
    send_word(lcnu_pkg::OP_TICK, 10'd0, lcnu_pkg::SYN_AMPA, 24'd0);
    send_word(lcnu_pkg::OP_TICK, 10'd0, lcnu_pkg::SYN_GAP, 24'hFFFFFF);
    send_word(lcnu_pkg::OP_EVENT, 10'd1023, lcnu_pkg::SYN_AMPA, 24'hFFFFFF);
    send_word(lcnu_pkg::OP_EVENT, 10'd1023, lcnu_pkg::SYN_AMPA, 24'hFFFFFF);
    send_word(lcnu_pkg::OP_EVENT, 10'd1023, lcnu_pkg::SYN_NMDA, 24'hAAAAAA);
    send_word(lcnu_pkg::OP_EVENT, 10'd1023, lcnu_pkg::SYN_NMDA, 24'h555555);
    send_word(lcnu_pkg::OP_TICK, 10'd1023, lcnu_pkg::SYN_NMDA, 24'd0);
    send_word(lcnu_pkg::OP_TICK, 10'd1023, lcnu_pkg::SYN_INH, 24'd0);
    send_word(lcnu_pkg::OP_TICK, 10'd1023, lcnu_pkg::SYN_AMPA, 24'd0);
    send_word(lcnu_pkg::OP_EVENT, 10'd5, lcnu_pkg::SYN_INH, 24'hFFFFFF);
    send_word(lcnu_pkg::OP_TICK, 10'd5, lcnu_pkg::SYN_AMPA, 24'd0);
    send_word(lcnu_pkg::OP_TICK, 10'd5, lcnu_pkg::SYN_AMPA, 24'd0);
    drain();

    // random phases, each with its own register set and a small neuron pool
    foreach (kinds[p]) begin
      load_regs(kinds[p]);
      foreach (pool[i]) pool[i] = 10'($urandom());
      pool[0] = 10'd0;
      pool[1] = 10'd1023;
      // potential overflow: big drive into one neuron under the high set
      if (kinds[p] == 1) begin
        send_word(lcnu_pkg::OP_EVENT, pool[2], lcnu_pkg::SYN_AMPA, 24'hFFFFFF);
        send_word(lcnu_pkg::OP_TICK, pool[2], lcnu_pkg::SYN_AMPA, 24'd0);
      end
      for (int k = 0; k < 200; k++) begin
        w = ($urandom_range(3) == 0) ? 24'($urandom()) : 24'($urandom_range(40000));
        send_word(($urandom_range(99) < 40) ? lcnu_pkg::OP_TICK : lcnu_pkg::OP_EVENT,
                  ($urandom_range(9) == 0) ? 10'($urandom()) : pool[$urandom_range(5)],
                  2'($urandom()), w);
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
